// File: design/mdns_pkg.sv
package mdns_pkg;

    localparam int NAME_BYTES = 63;
    localparam int NAME_AW = 6;

    localparam logic [7:0] POINTER_MARK = 8'hC0;
    localparam logic [3:0] HEADER_LAST = 4'd11;
    localparam logic [3:0] FIXED_LAST = 4'd9;
    localparam logic [3:0] QFIXED_LAST = 4'd3;
    localparam logic [15:0] TYPE_A = 16'd1;
    localparam logic [15:0] TYPE_TXT = 16'd16;
    localparam logic [7:0] FN_F = 8'h66;
    localparam logic [7:0] FN_N = 8'h6E;
    localparam logic [7:0] FN_EQ = 8'h3D;

    typedef enum logic [1:0] {
        KIND_SKIP = 2'd0,
        KIND_A    = 2'd1,
        KIND_TXT  = 2'd2
    } kind_t;

    // controller -> datapath
    typedef struct packed {
        logic       take;      // parse the accepted byte
        logic       flush;     // read name entry at flush index
        logic [5:0] flush_idx;
        logic       clear;     // clear parse state after summary
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic        name_valid;
        logic [5:0]  name_count;
        logic        name_cut;
        logic        address_valid;
        logic [31:0] address_kept;
    } dp_stat_t;

endpackage

// File: design/mdns_datapath.sv
module mdns_datapath
    import mdns_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_cmd_t    cmd,
    input  logic [7:0] packet_byte,
    output dp_stat_t   stat,
    output logic [7:0] name_rd
);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_QNAME = 3'd1;
    localparam logic [2:0] PH_QFIXED = 3'd2;
    localparam logic [2:0] PH_RNAME = 3'd3;
    localparam logic [2:0] PH_RFIXED = 3'd4;
    localparam logic [2:0] PH_RDATA = 3'd5;
    localparam logic [2:0] PH_DONE = 3'd6;

    logic [7:0] name_mem [0:63];

    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  pos_reg, pos_next;
    logic [15:0] q_reg, q_next;
    logic [17:0] rec_reg, rec_next;
    logic [7:0]  skip_reg, skip_next;
    logic [15:0] rtype_reg, rtype_next;
    logic [15:0] dleft_reg, dleft_next;
    logic [7:0]  sleft_reg, sleft_next;
    logic [1:0]  pm_reg, pm_next;
    logic [31:0] acand_reg, acand_next;
    logic [31:0] akept_reg, akept_next;
    logic        aval_reg, aval_next;
    logic [5:0]  ncnt_reg, ncnt_next;
    logic [5:0]  ccnt_reg, ccnt_next;
    logic        nval_reg, nval_next;
    logic        ptail_reg, ptail_next;
    kind_t       kind_reg, kind_next;
    logic        tstop_reg, tstop_next;
    logic        mism_reg, mism_next;
    logic        npend_reg, npend_next;
    logic        ccut_reg, ccut_next;
    logic        ncut_reg, ncut_next;
    logic        wr_en;
    logic [5:0]  wr_addr;

    logic [7:0] b;
    assign b = packet_byte;

    always_comb
    begin
        logic        name_end;
        logic [15:0] hv;
        logic [15:0] dl;
        logic [7:0]  pfx;
        logic        fin;
        phase_next = phase_reg; pos_next = pos_reg; q_next = q_reg;
        rec_next = rec_reg; skip_next = skip_reg; rtype_next = rtype_reg;
        dleft_next = dleft_reg; sleft_next = sleft_reg; pm_next = pm_reg;
        acand_next = acand_reg; akept_next = akept_reg; aval_next = aval_reg;
        ncnt_next = ncnt_reg; ccnt_next = ccnt_reg; nval_next = nval_reg;
        ptail_next = ptail_reg; kind_next = kind_reg; tstop_next = tstop_reg;
        mism_next = mism_reg; npend_next = npend_reg; ccut_next = ccut_reg;
        ncut_next = ncut_reg;
        wr_en = 1'b0; wr_addr = ccnt_reg;
        name_end = 1'b0; fin = 1'b0;
        hv = dleft_reg | {8'd0, b};
        dl = {dleft_reg[15:8], b};
        pfx = (pm_reg == 2'd0) ? FN_F : (pm_reg == 2'd1) ? FN_N : FN_EQ;

        // label walker shared by question and record names
        if (phase_reg == PH_QNAME || phase_reg == PH_RNAME) begin
            if (ptail_reg) begin
                ptail_next = 1'b0;
                name_end = 1'b1;
            end else if (skip_reg != 8'd0) begin
                skip_next = skip_reg - 8'd1;
            end else if (b == 8'd0) begin
                name_end = 1'b1;
            end else if ((b & POINTER_MARK) == POINTER_MARK) begin
                ptail_next = 1'b1;
            end else begin
                skip_next = b;
            end
        end

        if (cmd.take) begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (pos_reg >= 4'd4) begin
                        if (!pos_reg[0]) dleft_next = {b, 8'd0};
                        else if (pos_reg == 4'd5) q_next = hv;
                        else rec_next = rec_reg + {2'd0, hv};
                    end
                    if (pos_reg >= HEADER_LAST) begin
                        dleft_next = 16'd0;
                        pos_next = 4'd0; skip_next = 8'd0; ptail_next = 1'b0;
                        if (q_next != 16'd0) phase_next = PH_QNAME;
                        else phase_next = (rec_next != 18'd0) ? PH_RNAME : PH_DONE;
                    end else begin
                        pos_next = pos_reg + 4'd1;
                    end
                end
                PH_QNAME, PH_RNAME:
                begin
                    if (name_end) begin
                        phase_next = (phase_reg == PH_QNAME) ? PH_QFIXED : PH_RFIXED;
                        pos_next = 4'd0;
                    end
                end
                PH_QFIXED:
                begin
                    if (pos_reg >= QFIXED_LAST) begin
                        q_next = q_reg - 16'd1;
                        pos_next = 4'd0; skip_next = 8'd0; ptail_next = 1'b0;
                        if (q_next != 16'd0) phase_next = PH_QNAME;
                        else phase_next = (rec_reg != 18'd0) ? PH_RNAME : PH_DONE;
                    end else begin
                        pos_next = pos_reg + 4'd1;
                    end
                end
                PH_RFIXED:
                begin
                    if (pos_reg == 4'd0) rtype_next = {b, 8'd0};
                    else if (pos_reg == 4'd1) rtype_next = rtype_reg | {8'd0, b};
                    else if (pos_reg == 4'd8) dleft_next = {b, 8'd0};
                    if (pos_reg >= FIXED_LAST) begin
                        dleft_next = dl;
                        pos_next = 4'd0;
                        if (rtype_reg == TYPE_A && dl == 16'd4 && !aval_reg)
                            kind_next = KIND_A;
                        else if (rtype_reg == TYPE_TXT && !nval_reg)
                            kind_next = KIND_TXT;
                        else
                            kind_next = KIND_SKIP;
                        acand_next = 32'd0; sleft_next = 8'd0; pm_next = 2'd0;
                        mism_next = 1'b0; tstop_next = 1'b0; npend_next = 1'b0;
                        ccnt_next = 6'd0; ccut_next = 1'b0;
                        if (dl == 16'd0) fin = 1'b1;
                        else phase_next = PH_RDATA;
                    end else begin
                        pos_next = pos_reg + 4'd1;
                    end
                end
                PH_RDATA:
                begin
                    if (kind_reg == KIND_A) begin
                        acand_next = {acand_reg[23:0], b};
                    end else if (kind_reg == KIND_TXT && !tstop_reg) begin
                        if (sleft_reg == 8'd0) begin
                            if ({8'd0, b} > dleft_reg - 16'd1) begin
                                tstop_next = 1'b1;
                            end else begin
                                sleft_next = b; pm_next = 2'd0; mism_next = 1'b0;
                                ccnt_next = 6'd0; ccut_next = 1'b0;
                            end
                        end else begin
                            sleft_next = sleft_reg - 8'd1;
                            if (!mism_reg) begin
                                if (pm_reg != 2'd3) begin
                                    if (b == pfx) pm_next = pm_reg + 2'd1;
                                    else mism_next = 1'b1;
                                end else if (ccnt_reg < 6'(NAME_BYTES)) begin
                                    wr_en = 1'b1;
                                    ccnt_next = ccnt_reg + 6'd1;
                                end else begin
                                    ccut_next = 1'b1;
                                end
                            end
                            if (sleft_next == 8'd0 && !mism_next && pm_next == 2'd3) begin
                                npend_next = 1'b1;
                                tstop_next = 1'b1;
                            end
                        end
                    end
                    dleft_next = dleft_reg - 16'd1;
                    if (dleft_next == 16'd0) fin = 1'b1;
                end
                default:
                begin
                end
            endcase
            if (fin) begin
                if (kind_next == KIND_A) begin
                    akept_next = acand_next;
                    aval_next = 1'b1;
                end else if (kind_next == KIND_TXT && npend_next && ccnt_next != 6'd0) begin
                    nval_next = 1'b1;
                    ncnt_next = ccnt_next;
                    ncut_next = ccut_next;
                end
                rec_next = rec_reg - 18'd1;
                phase_next = (rec_next != 18'd0) ? PH_RNAME : PH_DONE;
                pos_next = 4'd0; skip_next = 8'd0; ptail_next = 1'b0;
            end
        end else begin
            skip_next = skip_reg;
            ptail_next = ptail_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_HEADER; pos_reg <= '0; q_reg <= '0; rec_reg <= '0;
            skip_reg <= '0; rtype_reg <= '0; dleft_reg <= '0; sleft_reg <= '0;
            pm_reg <= '0; acand_reg <= '0; akept_reg <= '0; aval_reg <= 1'b0;
            ncnt_reg <= '0; ccnt_reg <= '0; nval_reg <= 1'b0; ptail_reg <= 1'b0;
            kind_reg <= KIND_SKIP; tstop_reg <= 1'b0; mism_reg <= 1'b0;
            npend_reg <= 1'b0; ccut_reg <= 1'b0; ncut_reg <= 1'b0;
        end else if (cmd.clear) begin
            phase_reg <= PH_HEADER; pos_reg <= '0; q_reg <= '0; rec_reg <= '0;
            skip_reg <= '0; rtype_reg <= '0; dleft_reg <= '0; sleft_reg <= '0;
            pm_reg <= '0; acand_reg <= '0; akept_reg <= '0; aval_reg <= 1'b0;
            ncnt_reg <= '0; ccnt_reg <= '0; nval_reg <= 1'b0; ptail_reg <= 1'b0;
            kind_reg <= KIND_SKIP; tstop_reg <= 1'b0; mism_reg <= 1'b0;
            npend_reg <= 1'b0; ccut_reg <= 1'b0; ncut_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next; pos_reg <= pos_next; q_reg <= q_next;
            rec_reg <= rec_next; skip_reg <= skip_next; rtype_reg <= rtype_next;
            dleft_reg <= dleft_next; sleft_reg <= sleft_next; pm_reg <= pm_next;
            acand_reg <= acand_next; akept_reg <= akept_next; aval_reg <= aval_next;
            ncnt_reg <= ncnt_next; ccnt_reg <= ccnt_next; nval_reg <= nval_next;
            ptail_reg <= ptail_next; kind_reg <= kind_next; tstop_reg <= tstop_next;
            mism_reg <= mism_next; npend_reg <= npend_next; ccut_reg <= ccut_next;
            ncut_reg <= ncut_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take && wr_en)
            name_mem[wr_addr] <= b;
        if (cmd.flush)
            name_rd <= name_mem[cmd.flush_idx];
    end

    assign stat.name_valid = nval_next;
    assign stat.name_count = ncnt_next;
    assign stat.name_cut = ncut_next;
    assign stat.address_valid = aval_next;
    assign stat.address_kept = akept_next;

endmodule

// File: design/mdns_ctrl.sv
module mdns_ctrl
    import mdns_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_last,
    output logic        in_ready,
    input  dp_stat_t    stat,
    input  logic [7:0]  name_rd,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [47:0] out_data,
    output logic        out_user,
    output logic        out_last,
    output dp_cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_PARSE = 3'b001,
        ST_FLUSH = 3'b010,
        ST_SUM   = 3'b100
    } state_t;

    state_t      state_reg, state_next;
    logic [5:0]  idx_reg, idx_next;      // next entry to read
    logic [5:0]  len_reg, len_next;
    logic        ov_reg, ov_next;        // output word holds a name byte
    logic [31:0] addr_reg, addr_next;
    logic        af_reg, af_next;
    logic        cut_reg, cut_next;
    logic        sv_reg, sv_next;        // summary word on output
    logic        take;
    logic        out_fire;
    logic        rd_pend_reg;

    assign take = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;
    assign in_ready = (state_reg == ST_PARSE) && !out_valid;

    always_comb
    begin
        state_next = state_reg; idx_next = idx_reg; len_next = len_reg;
        ov_next = ov_reg; addr_next = addr_reg;
        af_next = af_reg; cut_next = cut_reg; sv_next = sv_reg;
        cmd = '0;
        cmd.take = take;
        cmd.flush_idx = idx_reg;
        if (out_fire) begin
            ov_next = 1'b0;
            sv_next = 1'b0;
        end
        unique case (state_reg)
            ST_PARSE:
            begin
                if (take && in_last) begin
                    len_next = stat.name_valid ? stat.name_count : 6'd0;
                    addr_next = stat.address_valid ? stat.address_kept : 32'd0;
                    af_next = stat.address_valid;
                    cut_next = stat.name_valid && stat.name_cut;
                    idx_next = 6'd0;
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                // read one entry per free output slot
                if (!rd_pend_reg && (!ov_reg || out_fire)) begin
                    if (idx_reg == len_reg) begin
                        state_next = ST_SUM;
                    end else begin
                        cmd.flush = 1'b1;
                        idx_next = idx_reg + 6'd1;
                    end
                end
            end
            ST_SUM:
            begin
                if (!ov_reg && !sv_reg) begin
                    sv_next = 1'b1;
                    cmd.clear = 1'b1;
                end else if (sv_reg && out_fire) begin
                    state_next = ST_PARSE;
                end
            end
            default:
            begin
                state_next = ST_PARSE;
            end
        endcase
        if (rd_pend_reg)
            ov_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_PARSE; idx_reg <= '0; len_reg <= '0; ov_reg <= 1'b0;
            af_reg <= 1'b0; cut_reg <= 1'b0; sv_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
        end else begin
            state_reg <= state_next; idx_reg <= idx_next; len_reg <= len_next;
            ov_reg <= ov_next; af_reg <= af_next;
            cut_reg <= cut_next; sv_reg <= sv_next;
            rd_pend_reg <= cmd.flush;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
    end

    assign out_valid = ov_reg || sv_reg;
    assign out_user = sv_reg;
    assign out_last = sv_reg;
    // fields low to high: name_char, ipv4_address, address_found,
    // name_length, name_truncated
    assign out_data = sv_reg ? {cut_reg, len_reg, af_reg, addr_reg, 8'd0}
                             : {40'd0, name_rd};

endmodule

// File: design/mdns_response_field_extractor_core.sv
// Channel   | Signals                                | Word
// s_axis    | s_axis_tvalid/tready/tdata/tlast       | tdata[7:0] packet_byte, tlast end_of_packet
// m_axis    | m_axis_tvalid/tready/tdata/tuser/tlast | tdata[47:0] result fields,
//           |                                        | tuser is_summary, tlast last_result
//
// One packet byte is taken per cycle while parsing; the parse datapath
// updates all record state in the cycle a byte is accepted.
// After the last byte the name buffer is read out one name word at a time (registered RAM
// read), each read issued once the previous word is taken, then the summary word follows.
// Input is held off from the last byte until the summary is taken; rst_n clears
// all control state.
module mdns_response_field_extractor_core
    import mdns_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // packet_byte
    input  logic        s_axis_tlast,   // end_of_packet
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // name_char, ipv4_address, address_found,
                                        // name_length, name_truncated
    output logic        m_axis_tuser,   // is_summary
    output logic        m_axis_tlast    // last_result
);

    dp_cmd_t    cmd;
    dp_stat_t   stat;
    logic [7:0] name_rd;

    mdns_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .packet_byte(s_axis_tdata),
        .stat(stat), .name_rd(name_rd)
    );

    mdns_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(s_axis_tvalid), .in_last(s_axis_tlast),
        .in_ready(s_axis_tready), .stat(stat), .name_rd(name_rd),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_data(m_axis_tdata), .out_user(m_axis_tuser), .out_last(m_axis_tlast),
        .cmd(cmd)
    );

`ifndef ASSERT_OFF
    a_no_take_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input taken during output");
    a_last_is_summary: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
        else $error("last result without summary flag");
    a_take_and_flush: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.take && cmd.flush)) else $error("parse during flush");
`endif

endmodule
